@@ hw/rtl/arp_responder_cache_core_macros.svh @@
// ----------------------------------------------------------------------------
// ARP responder cache assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ARP_RESPONDER_CACHE_CORE_MACROS_SVH
`define ARP_RESPONDER_CACHE_CORE_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define ARPC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arpc assertion failed");

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define ARPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arpc assertion failed");

`endif

@@ hw/rtl/arpc_pkg.sv @@
// ----------------------------------------------------------------------------
// ARP responder cache package
// Types, header constants, opcodes and status codes of the ARP cache core.
// ----------------------------------------------------------------------------
package arpc_pkg;

    // Default number of cache entries
    localparam int ENTRIES_DEF = 16;

    // Configuration register indexes
    localparam logic REG_OWN_MAC = 1'b0;
    localparam logic REG_OWN_IP  = 1'b1;

    // Item kinds
    localparam logic FUNC_PACKET = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // Accepted ARP header values
    localparam logic [15:0] HW_TYPE_ETH    = 16'h0001;
    localparam logic [15:0] PROTO_TYPE_IP4 = 16'h0800;
    localparam logic [7:0]  HW_LEN_ETH     = 8'd6;
    localparam logic [7:0]  PROTO_LEN_IP4  = 8'd4;

    // Received opcode of an ARP request
    localparam logic [15:0] ARP_OP_REQUEST = 16'd1;

    // Transmitted opcodes
    localparam logic [1:0] SEND_OP_NONE    = 2'd0;
    localparam logic [1:0] SEND_OP_REQUEST = 2'd1;
    localparam logic [1:0] SEND_OP_REPLY   = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_REQ_SENT = 2'd1;
    localparam logic [1:0] STATUS_REJECTED = 2'd2;
    localparam logic [1:0] STATUS_FULL     = 2'd3;

    // Broadcast hardware address
    localparam logic [47:0] MAC_BROADCAST = 48'hFFFF_FFFF_FFFF;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } arpc_state_t;

endpackage

@@ hw/rtl/arp_responder_cache_core.sv @@
// ----------------------------------------------------------------------------
// ARP responder cache core
// Learns IPv4 to MAC pairs from parsed ARP packets, answers requests for
// this station's address and resolves lookups against the cache.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive func and the packet or lookup fields with start
//   high; the transfer happens at the edge where start is high and busy is
//   low. busy stays high until the result has been registered.
//   Result channel: done pulses for one cycle with all result fields valid;
//   the receiver cannot stall and must take the result in that cycle.
//   Configuration: own_mac and own_ip are written through cfg_we, cfg_index
//   and cfg_data while the core is idle; no read-back.
//   Timing: a packet or lookup walks the cache one entry per cycle through
//   the single registered read port of the entry memory and one shared
//   address comparator. A matching entry ends the walk early, and a rejected
//   header skips the walk. A new start is taken in the cycle done is high,
//   so a new item is taken only after the last one is through.
//   Reset: all entries are marked free and the count is cleared at once;
//   own_mac and own_ip return to zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "arp_responder_cache_core_macros.svh"

module arp_responder_cache_core #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [47:0] cfg_data,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [15:0] hw_type,
    input  logic [15:0] proto_type,
    input  logic [7:0]  hw_len,
    input  logic [7:0]  proto_len,
    input  logic [15:0] op_code,
    input  logic [47:0] sender_mac,
    input  logic [31:0] sender_ip,
    input  logic [31:0] target_ip,
    input  logic [31:0] lookup_ip,
    // result channel
    output logic        done,
    output logic        send_valid,
    output logic [1:0]  send_opcode,
    output logic [47:0] send_dest_mac,
    output logic [31:0] send_target_ip,
    output logic        lookup_hit,
    output logic [47:0] lookup_mac,
    output logic [1:0]  status,
    output logic [4:0]  entry_count
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    // Configuration registers
    logic [47:0] own_mac_reg;
    logic [31:0] own_ip_reg;

    // Sequencer
    arpc_pkg::arpc_state_t state_reg, state_next;

    // Captured command
    logic        func_reg;
    logic        hdr_ok_reg;
    logic [15:0] op_code_reg;
    logic [47:0] sender_mac_reg;
    logic [31:0] sender_ip_reg;
    logic [31:0] target_ip_reg;
    logic [31:0] key_reg;

    // Scan control
    logic [IW:0]   scan_cnt_reg, scan_cnt_next;
    logic          rd_live_reg, rd_live_next;
    logic [IW-1:0] rd_idx_reg;
    logic          hit_reg, hit_next;
    logic [IW-1:0] hit_idx_reg;
    logic [47:0]   hit_mac_reg;
    logic          free_found_reg, free_found_next;
    logic [IW-1:0] free_idx_reg;

    // Cache state
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [31:0]        cache_ip_mem  [ENTRIES];
    logic [47:0]        cache_mac_mem [ENTRIES];
    logic [31:0]        ip_rd_reg;
    logic [47:0]        mac_rd_reg;

    // Memory write controls
    logic          ip_we;
    logic          mac_we;
    logic [IW-1:0] wr_addr;

    // Result registers
    logic        done_reg, done_next;
    logic        send_valid_reg, send_valid_next;
    logic [1:0]  send_opcode_reg, send_opcode_next;
    logic [47:0] send_dest_mac_reg, send_dest_mac_next;
    logic [31:0] send_target_ip_reg, send_target_ip_next;
    logic        lookup_hit_reg, lookup_hit_next;
    logic [47:0] lookup_mac_reg, lookup_mac_next;
    logic [1:0]  status_reg, status_next;
    logic [4:0]  entry_count_reg, entry_count_next;

    logic accept;
    logic hdr_ok_in;
    logic entry_match;
    logic last_entry;
    logic scan_end;
    logic stored;

    assign accept    = start && (state_reg == arpc_pkg::ST_IDLE);
    assign hdr_ok_in = (hw_type == arpc_pkg::HW_TYPE_ETH)
                    && (proto_type == arpc_pkg::PROTO_TYPE_IP4)
                    && (hw_len == arpc_pkg::HW_LEN_ETH)
                    && (proto_len == arpc_pkg::PROTO_LEN_IP4);

    // Shared comparator on the entry read back last cycle
    assign entry_match = rd_live_reg && valid_reg[rd_idx_reg] && (ip_rd_reg == key_reg);
    assign last_entry  = rd_idx_reg == IW'(ENTRIES - 1);
    assign scan_end    = rd_live_reg && (entry_match || last_entry);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            arpc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (func == arpc_pkg::FUNC_LOOKUP || hdr_ok_in)
                        state_next = arpc_pkg::ST_SCAN;
                    else
                        state_next = arpc_pkg::ST_FINISH;
                end
            end
            arpc_pkg::ST_SCAN:
            begin
                if (scan_end)
                    state_next = arpc_pkg::ST_FINISH;
            end
            arpc_pkg::ST_FINISH:
            begin
                state_next = arpc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = arpc_pkg::ST_IDLE;
            end
        endcase
    end

    // Scan datapath: advance the read address, record hit and first free entry
    always_comb
    begin
        scan_cnt_next   = scan_cnt_reg;
        rd_live_next    = 1'b0;
        hit_next        = hit_reg;
        free_found_next = free_found_reg;
        if (accept)
        begin
            scan_cnt_next   = '0;
            hit_next        = 1'b0;
            free_found_next = 1'b0;
        end
        else if (state_reg == arpc_pkg::ST_SCAN && !scan_end)
        begin
            if (scan_cnt_reg < (IW + 1)'(ENTRIES))
            begin
                rd_live_next  = 1'b1;
                scan_cnt_next = scan_cnt_reg + 1'b1;
            end
        end
        if (state_reg == arpc_pkg::ST_SCAN && entry_match)
            hit_next = 1'b1;
        if (state_reg == arpc_pkg::ST_SCAN && rd_live_reg && !valid_reg[rd_idx_reg])
            free_found_next = 1'b1;
    end

    // Finish: update the cache and form the result
    always_comb
    begin
        valid_next          = valid_reg;
        count_next          = count_reg;
        ip_we               = 1'b0;
        mac_we              = 1'b0;
        wr_addr             = hit_idx_reg;
        stored              = 1'b0;
        done_next           = 1'b0;
        send_valid_next     = 1'b0;
        send_opcode_next    = arpc_pkg::SEND_OP_NONE;
        send_dest_mac_next  = '0;
        send_target_ip_next = '0;
        lookup_hit_next     = 1'b0;
        lookup_mac_next     = '0;
        status_next         = arpc_pkg::STATUS_OK;
        if (state_reg == arpc_pkg::ST_FINISH)
        begin
            done_next = 1'b1;
            if (func_reg == arpc_pkg::FUNC_PACKET)
            begin
                if (!hdr_ok_reg)
                    status_next = arpc_pkg::STATUS_REJECTED;
                else if (hit_reg)
                begin
                    mac_we = 1'b1;
                    stored = 1'b1;
                end
                else if (free_found_reg)
                begin
                    wr_addr                 = free_idx_reg;
                    ip_we                   = 1'b1;
                    mac_we                  = 1'b1;
                    valid_next[free_idx_reg] = 1'b1;
                    count_next              = count_reg + 1'b1;
                    stored                  = 1'b1;
                end
                else
                    status_next = arpc_pkg::STATUS_FULL;
                if (stored && op_code_reg == arpc_pkg::ARP_OP_REQUEST
                    && target_ip_reg == own_ip_reg)
                begin
                    send_valid_next     = 1'b1;
                    send_opcode_next    = arpc_pkg::SEND_OP_REPLY;
                    send_dest_mac_next  = sender_mac_reg;
                    send_target_ip_next = sender_ip_reg;
                end
            end
            else
            begin
                if (hit_reg)
                begin
                    lookup_hit_next = 1'b1;
                    lookup_mac_next = hit_mac_reg;
                end
                else
                begin
                    send_valid_next     = 1'b1;
                    send_opcode_next    = arpc_pkg::SEND_OP_REQUEST;
                    send_dest_mac_next  = arpc_pkg::MAC_BROADCAST;
                    send_target_ip_next = key_reg;
                    status_next         = arpc_pkg::STATUS_REQ_SENT;
                end
            end
        end
        entry_count_next = 5'(count_next);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= arpc_pkg::ST_IDLE;
            own_mac_reg    <= '0;
            own_ip_reg     <= '0;
            valid_reg      <= '0;
            count_reg      <= '0;
            scan_cnt_reg   <= '0;
            rd_live_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            scan_cnt_reg   <= scan_cnt_next;
            rd_live_reg    <= rd_live_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            done_reg       <= done_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    arpc_pkg::REG_OWN_MAC: own_mac_reg <= cfg_data;
                    arpc_pkg::REG_OWN_IP:  own_ip_reg  <= cfg_data[31:0];
                    default:               own_ip_reg  <= own_ip_reg;
                endcase
            end
        end
    end

    // Payload registers: capture the command, hit and free positions, result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg       <= func;
            hdr_ok_reg     <= hdr_ok_in;
            op_code_reg    <= op_code;
            sender_mac_reg <= sender_mac;
            sender_ip_reg  <= sender_ip;
            target_ip_reg  <= target_ip;
            key_reg        <= (func == arpc_pkg::FUNC_LOOKUP) ? lookup_ip : sender_ip;
        end
        rd_idx_reg <= scan_cnt_reg[IW-1:0];
        if (state_reg == arpc_pkg::ST_SCAN && entry_match)
        begin
            hit_idx_reg <= rd_idx_reg;
            hit_mac_reg <= mac_rd_reg;
        end
        if (state_reg == arpc_pkg::ST_SCAN && rd_live_reg && !valid_reg[rd_idx_reg]
            && !free_found_reg)
            free_idx_reg <= rd_idx_reg;
        if (state_reg == arpc_pkg::ST_FINISH)
        begin
            send_valid_reg     <= send_valid_next;
            send_opcode_reg    <= send_opcode_next;
            send_dest_mac_reg  <= send_dest_mac_next;
            send_target_ip_reg <= send_target_ip_next;
            lookup_hit_reg     <= lookup_hit_next;
            lookup_mac_reg     <= lookup_mac_next;
            status_reg         <= status_next;
            entry_count_reg    <= entry_count_next;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ip_we)
            cache_ip_mem[wr_addr] <= sender_ip_reg;
        if (mac_we)
            cache_mac_mem[wr_addr] <= sender_mac_reg;
        ip_rd_reg  <= cache_ip_mem[scan_cnt_reg[IW-1:0]];
        mac_rd_reg <= cache_mac_mem[scan_cnt_reg[IW-1:0]];
    end

    assign busy           = state_reg != arpc_pkg::ST_IDLE;
    assign done           = done_reg;
    assign send_valid     = send_valid_reg;
    assign send_opcode    = send_opcode_reg;
    assign send_dest_mac  = send_dest_mac_reg;
    assign send_target_ip = send_target_ip_reg;
    assign lookup_hit     = lookup_hit_reg;
    assign lookup_mac     = lookup_mac_reg;
    assign status         = status_reg;
    assign entry_count    = entry_count_reg;

    // Assertions
    `ARPC_ASSERT_IMPLIES(a_count_matches_valid, clk, rst_n, 1'b1, ($countones(valid_reg) == count_reg))
    `ARPC_ASSERT_NEXT(a_finish_gives_done, clk, rst_n, (state_reg == arpc_pkg::ST_FINISH), (done_reg && !busy))
    `ARPC_ASSERT_NEXT(a_accept_sets_busy, clk, rst_n, (start && !busy), busy)
    `ARPC_ASSERT_IMPLIES(a_hit_clean_result, clk, rst_n, (done && lookup_hit), (!send_valid && status == arpc_pkg::STATUS_OK))
    `ARPC_ASSERT_IMPLIES(a_scan_read_in_range, clk, rst_n, rd_live_reg, (state_reg == arpc_pkg::ST_SCAN))

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ARP responder cache core testbench
// Drives received ARP packets and cache lookups through the command channel,
// predicts every result with a cycle-free model of the cache and checks each
// done strobe field by field, over several station addresses and idle mixes.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CACHE_SLOTS = arpc_pkg::ENTRIES_DEF;
    localparam int POOL_SIZE   = 20;
    localparam int SETTLE_CYCLES = CACHE_SLOTS + 4;

    // Received opcode of an ARP reply
    localparam logic [15:0] ARP_OP_REPLY = 16'd2;

    // One command transfer
    typedef struct packed {
        logic        func;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_len;
        logic [7:0]  proto_len;
        logic [15:0] op_code;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
        logic [31:0] lookup_ip;
    } arp_item_t;

    // One result transfer
    typedef struct packed {
        logic        send_valid;
        logic [1:0]  send_opcode;
        logic [47:0] send_dest_mac;
        logic [31:0] send_target_ip;
        logic        lookup_hit;
        logic [47:0] lookup_mac;
        logic [1:0]  status;
        logic [4:0]  entry_count;
    } arp_outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = arpc_pkg::REG_OWN_MAC;
    logic [47:0] cfg_data = '0;
    logic        start = 1'b0;
    logic        busy;
    logic        func = arpc_pkg::FUNC_PACKET;
    logic [15:0] hw_type = '0;
    logic [15:0] proto_type = '0;
    logic [7:0]  hw_len = '0;
    logic [7:0]  proto_len = '0;
    logic [15:0] op_code = '0;
    logic [47:0] sender_mac = '0;
    logic [31:0] sender_ip = '0;
    logic [31:0] target_ip = '0;
    logic [31:0] lookup_ip = '0;
    logic        done;
    logic        send_valid;
    logic [1:0]  send_opcode;
    logic [47:0] send_dest_mac;
    logic [31:0] send_target_ip;
    logic        lookup_hit;
    logic [47:0] lookup_mac;
    logic [1:0]  status;
    logic [4:0]  entry_count;

    arp_responder_cache_core #(
        .ENTRIES(CACHE_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .start(start),
        .busy(busy),
        .func(func),
        .hw_type(hw_type),
        .proto_type(proto_type),
        .hw_len(hw_len),
        .proto_len(proto_len),
        .op_code(op_code),
        .sender_mac(sender_mac),
        .sender_ip(sender_ip),
        .target_ip(target_ip),
        .lookup_ip(lookup_ip),
        .done(done),
        .send_valid(send_valid),
        .send_opcode(send_opcode),
        .send_dest_mac(send_dest_mac),
        .send_target_ip(send_target_ip),
        .lookup_hit(lookup_hit),
        .lookup_mac(lookup_mac),
        .status(status),
        .entry_count(entry_count)
    );

    // Predicted cache contents and station address
    logic        slot_used [CACHE_SLOTS];
    logic [31:0] slot_ip   [CACHE_SLOTS];
    logic [47:0] slot_mac  [CACHE_SLOTS];
    logic [4:0]  used_slots;
    logic [31:0] station_ip;

    // Stimulus and expected results
    arp_item_t    arp_items_q[$];
    arp_outcome_t arp_outcomes_q[$];
    arp_item_t    cur_item;
    logic [31:0]  ip_pool [POOL_SIZE];
    int           gap_pct = 0;
    bit           hold_for_drain = 1'b0;
    int           accepted_cnt = 0;
    int           answered_cnt = 0;
    int           mismatch_count = 0;

    always #1 clk = ~clk;

    function automatic logic [47:0] rand48();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[47:0];
    endfunction

    function automatic logic [31:0] pool_ip();
        return ip_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    // Resolve one item against the predicted cache, updating it as the block would
    function automatic arp_outcome_t resolve_arp_item(arp_item_t it);
        arp_outcome_t res;
        int hit;
        int slot;
        res = '0;
        hit = -1;
        slot = -1;
        if (it.func == arpc_pkg::FUNC_PACKET)
        begin
            if (it.hw_type != arpc_pkg::HW_TYPE_ETH ||
                it.proto_type != arpc_pkg::PROTO_TYPE_IP4 ||
                it.hw_len != arpc_pkg::HW_LEN_ETH ||
                it.proto_len != arpc_pkg::PROTO_LEN_IP4)
            begin
                res.status = arpc_pkg::STATUS_REJECTED;
            end
            else
            begin
                for (int i = 0; i < CACHE_SLOTS; i++)
                    if (hit < 0 && slot_used[i] && slot_ip[i] == it.sender_ip)
                        hit = i;
                // new sender goes into the lowest free slot
                if (hit < 0)
                begin
                    for (int i = 0; i < CACHE_SLOTS; i++)
                        if (slot < 0 && !slot_used[i])
                            slot = i;
                    if (slot >= 0)
                    begin
                        slot_used[slot] = 1'b1;
                        slot_ip[slot] = it.sender_ip;
                        used_slots = used_slots + 5'd1;
                        hit = slot;
                    end
                end
                if (hit < 0)
                begin
                    res.status = arpc_pkg::STATUS_FULL;
                end
                else
                begin
                    slot_mac[hit] = it.sender_mac;
                    res.status = arpc_pkg::STATUS_OK;
                    if (it.op_code == arpc_pkg::ARP_OP_REQUEST && it.target_ip == station_ip)
                    begin
                        res.send_valid = 1'b1;
                        res.send_opcode = arpc_pkg::SEND_OP_REPLY;
                        res.send_dest_mac = it.sender_mac;
                        res.send_target_ip = it.sender_ip;
                    end
                end
            end
        end
        else
        begin
            for (int i = 0; i < CACHE_SLOTS; i++)
                if (hit < 0 && slot_used[i] && slot_ip[i] == it.lookup_ip)
                    hit = i;
            if (hit >= 0)
            begin
                res.lookup_hit = 1'b1;
                res.lookup_mac = slot_mac[hit];
                res.status = arpc_pkg::STATUS_OK;
            end
            else
            begin
                res.send_valid = 1'b1;
                res.send_opcode = arpc_pkg::SEND_OP_REQUEST;
                res.send_dest_mac = arpc_pkg::MAC_BROADCAST;
                res.send_target_ip = it.lookup_ip;
                res.status = arpc_pkg::STATUS_REQ_SENT;
            end
        end
        res.entry_count = used_slots;
        return res;
    endfunction

    function automatic arp_item_t arp_packet(logic [15:0] op, logic [47:0] smac,
                                             logic [31:0] sip, logic [31:0] tip);
        arp_item_t it;
        it.func = arpc_pkg::FUNC_PACKET;
        it.hw_type = arpc_pkg::HW_TYPE_ETH;
        it.proto_type = arpc_pkg::PROTO_TYPE_IP4;
        it.hw_len = arpc_pkg::HW_LEN_ETH;
        it.proto_len = arpc_pkg::PROTO_LEN_IP4;
        it.op_code = op;
        it.sender_mac = smac;
        it.sender_ip = sip;
        it.target_ip = tip;
        it.lookup_ip = '0;
        return it;
    endfunction

    function automatic arp_item_t arp_lookup(logic [31:0] ip);
        arp_item_t it;
        it = '0;
        it.func = arpc_pkg::FUNC_LOOKUP;
        it.lookup_ip = ip;
        return it;
    endfunction

    // Mostly well-formed packets and lookups on a small address pool, some noise
    function automatic arp_item_t random_arp_item();
        arp_item_t it;
        int pick;
        int op_pick;
        pick = $urandom_range(99);
        op_pick = $urandom_range(3);
        it = arp_packet(arpc_pkg::ARP_OP_REQUEST, rand48(),
                        ($urandom_range(9) == 0) ? $urandom() : pool_ip(),
                        ($urandom_range(4) < 2) ? station_ip :
                        (($urandom_range(1) == 0) ? pool_ip() : $urandom()));
        it.lookup_ip = $urandom();
        if (op_pick == 2)
            it.op_code = ARP_OP_REPLY;
        else if (op_pick == 3)
            it.op_code = 16'($urandom());
        if (pick < 35)
        begin
            it.func = arpc_pkg::FUNC_LOOKUP;
            it.lookup_ip = ($urandom_range(4) == 0) ? $urandom() : pool_ip();
            it.hw_type = 16'($urandom());
            it.proto_type = 16'($urandom());
            it.hw_len = 8'($urandom());
            it.proto_len = 8'($urandom());
        end
        else if (pick >= 85)
        begin
            // corrupt the header
            case ($urandom_range(4))
                0: it.hw_type = 16'($urandom());
                1: it.proto_type = 16'($urandom());
                2: it.hw_len = 8'($urandom());
                3: it.proto_len = 8'($urandom());
                default:
                begin
                    it.hw_type = 16'($urandom());
                    it.proto_type = 16'($urandom());
                    it.hw_len = 8'($urandom());
                    it.proto_len = 8'($urandom());
                end
            endcase
        end
        return it;
    endfunction

    function automatic int field_differs(string name, logic [47:0] want, logic [47:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Register write; the predictor follows at once since the core is idle
    task automatic write_reg(logic idx, logic [47:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == arpc_pkg::REG_OWN_IP)
            station_ip = data[31:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (arp_items_q.size() != 0 || start || accepted_cnt != answered_cnt)
            @(negedge clk);
    endtask

    task automatic run_phase(int n, int gap, bit hold, logic [47:0] mac, logic [31:0] ip);
        write_reg(arpc_pkg::REG_OWN_MAC, mac);
        write_reg(arpc_pkg::REG_OWN_IP, {16'(rand48() >> 32), ip});
        @(negedge clk);
        gap_pct = gap;
        hold_for_drain = hold;
        repeat (n) arp_items_q.push_back(random_arp_item());
        wait_drained();
    endtask

    // Command driver: present the next item once the current one is transferred
    always @(posedge clk)
    begin : drive_items
        logic take_next;
        logic xfer;
        logic in_flight;
        xfer = start && !busy;
        take_next = !start || !busy;
        in_flight = (accepted_cnt + int'(xfer)) != answered_cnt;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (xfer)
            begin
                arp_outcomes_q.push_back(resolve_arp_item(cur_item));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (take_next)
            begin
                if (arp_items_q.size() != 0 && $urandom_range(99) >= gap_pct &&
                    !(hold_for_drain && in_flight))
                begin
                    cur_item = arp_items_q.pop_front();
                    start <= 1'b1;
                    func <= cur_item.func;
                    hw_type <= cur_item.hw_type;
                    proto_type <= cur_item.proto_type;
                    hw_len <= cur_item.hw_len;
                    proto_len <= cur_item.proto_len;
                    op_code <= cur_item.op_code;
                    sender_mac <= cur_item.sender_mac;
                    sender_ip <= cur_item.sender_ip;
                    target_ip <= cur_item.target_ip;
                    lookup_ip <= cur_item.lookup_ip;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each done strobe with the oldest prediction
    always @(posedge clk)
    begin : check_results
        arp_outcome_t want;
        int errs;
        if (rst_n && done)
        begin
            answered_cnt <= answered_cnt + 1;
            if (arp_outcomes_q.size() == 0)
            begin
                $error("result transfer with no item outstanding");
                mismatch_count++;
            end
            else
            begin
                want = arp_outcomes_q.pop_front();
                errs = 0;
                errs += field_differs("send_valid", 48'(want.send_valid),
                                      48'(send_valid));
                errs += field_differs("send_opcode", 48'(want.send_opcode),
                                      48'(send_opcode));
                errs += field_differs("send_dest_mac", want.send_dest_mac, send_dest_mac);
                errs += field_differs("send_target_ip", 48'(want.send_target_ip),
                                      48'(send_target_ip));
                errs += field_differs("lookup_hit", 48'(want.lookup_hit),
                                      48'(lookup_hit));
                errs += field_differs("lookup_mac", want.lookup_mac, lookup_mac);
                errs += field_differs("status", 48'(want.status), 48'(status));
                errs += field_differs("entry_count", 48'(want.entry_count),
                                      48'(entry_count));
                mismatch_count += errs;
            end
        end
    end

    // Stimulus sequence
    initial
    begin : stimulus
        arp_item_t it;
        logic [31:0] own;
        for (int i = 0; i < CACHE_SLOTS; i++)
        begin
            slot_used[i] = 1'b0;
            slot_ip[i] = '0;
            slot_mac[i] = '0;
        end
        used_slots = '0;
        station_ip = '0;
        ip_pool[0] = 32'h0000_0000;
        ip_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            ip_pool[i] = $urandom();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part
        own = 32'hC0A8_0001;
        write_reg(arpc_pkg::REG_OWN_MAC, arpc_pkg::MAC_BROADCAST);
        write_reg(arpc_pkg::REG_OWN_IP, {16'hFFFF, own});
        @(negedge clk);
        arp_items_q.push_back(arp_lookup(ip_pool[2]));
        arp_items_q.push_back(arp_packet(arpc_pkg::ARP_OP_REQUEST, rand48(), ip_pool[2], own));
        arp_items_q.push_back(arp_lookup(ip_pool[2]));
        arp_items_q.push_back(arp_packet(ARP_OP_REPLY, rand48(), ip_pool[2], own));
        arp_items_q.push_back(arp_lookup(ip_pool[2]));
        // low byte alone looks like a request
        arp_items_q.push_back(arp_packet(16'h0101, rand48(), ip_pool[3], own));
        arp_items_q.push_back(arp_packet(16'hFFFF, 48'h0, ip_pool[0], own));
        arp_items_q.push_back(arp_packet(16'h0000, arpc_pkg::MAC_BROADCAST, ip_pool[1], own));
        arp_items_q.push_back(arp_packet(arpc_pkg::ARP_OP_REQUEST, rand48(), ip_pool[4],
                                         own ^ 32'd1));
        // rejected headers, each a request for this station
        it = arp_packet(arpc_pkg::ARP_OP_REQUEST, rand48(), ip_pool[5], own);
        it.hw_type = 16'h0000;
        arp_items_q.push_back(it);
        it.hw_type = 16'hFFFF;
        arp_items_q.push_back(it);
        it.hw_type = arpc_pkg::HW_TYPE_ETH;
        it.proto_type = 16'hFFFF;
        arp_items_q.push_back(it);
        it.proto_type = 16'h0000;
        arp_items_q.push_back(it);
        it.proto_type = arpc_pkg::PROTO_TYPE_IP4;
        it.hw_len = 8'h00;
        arp_items_q.push_back(it);
        it.hw_len = 8'hFF;
        arp_items_q.push_back(it);
        it.hw_len = arpc_pkg::HW_LEN_ETH;
        it.proto_len = 8'h00;
        arp_items_q.push_back(it);
        it.proto_len = 8'hFF;
        arp_items_q.push_back(it);
        arp_items_q.push_back(arp_lookup(ip_pool[5]));
        arp_items_q.push_back(arp_lookup(ip_pool[0]));
        arp_items_q.push_back(arp_lookup(ip_pool[1]));
        arp_items_q.push_back(arp_packet(arpc_pkg::ARP_OP_REQUEST, rand48(), ip_pool[1], own));
        arp_items_q.push_back(arp_lookup(32'hFFFF_FFFE));
        wait_drained();

        // Random part over several station settings and idle mixes
        run_phase(130, 0, 1'b0, 48'h0, 32'h0);
        run_phase(130, 73, 1'b0, rand48(), 32'hFFFF_FFFF);
        run_phase(100, 11, 1'b0, arpc_pkg::MAC_BROADCAST, ip_pool[6]);
        run_phase(40, 0, 1'b1, rand48(), $urandom());

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && arp_outcomes_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Run limit
    initial
    begin : watchdog
        #200_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
